@@ rtl/core/lrs_pkg.sv @@
// Shared constants and types for the label region statistics block.
// No dependencies.
package lrs_pkg;
  localparam int GROUPS = 256;
  localparam int GW = $clog2(GROUPS);
  localparam int NSL = 4;
  localparam int NFL = 3;
  localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;
  localparam logic [0:0] ACT_ACC = 1'b0;
  localparam logic [0:0] ACT_READ = 1'b1;
  localparam logic [0:0] REG_LIMIT = 1'b0;
  localparam logic [0:0] REG_SURF = 1'b1;

  // One queued command between the front and back parts.
  typedef struct packed {
    logic              rd;
    logic              surf;
    logic [GW-1:0]     grp;
    logic [1:0]        lane;
    logic [9:0]        depth;
    logic [9:0]        tstep;
    logic [NSL*16-1:0] sc;
    logic [NFL*16-1:0] sf;
  } cmd_t;

  function automatic logic [47:0] sat_add(input logic [47:0] s, input logic [15:0] v);
    logic [48:0] r;
    r = {s[47], s} + {{33{v[15]}}, v};
    if (r[48] != r[47]) sat_add = r[48] ? SUM_MIN : SUM_MAX;
    else sat_add = r[47:0];
  endfunction

  function automatic logic [15:0] upd_min(input logic [15:0] c, input logic [15:0] v);
    logic signed [15:0] cc;
    cc = (c == 16'd0) ? v : c;
    upd_min = ($signed(v) < cc) ? v : cc;
  endfunction

  function automatic logic [15:0] upd_max(input logic [15:0] c, input logic [15:0] v);
    logic signed [15:0] cc;
    cc = (c == 16'd0) ? v : c;
    upd_max = ($signed(v) > cc) ? v : cc;
  endfunction

  function automatic logic [15:0] upd_ext(input logic [15:0] c, input logic [15:0] v);
    logic [16:0] av;
    logic [16:0] ac;
    av = v[15] ? 17'd0 - {v[15], v} : {1'b0, v};
    ac = c[15] ? 17'd0 - {c[15], c} : {1'b0, c};
    upd_ext = (c == 16'd0 || av > ac) ? v : c;
  endfunction
endpackage

@@ rtl/core/lrs_front.sv @@
// Front part: registers, classification of each beat into a command.
// Depends on lrs_pkg.
module lrs_front import lrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        take,
  input  logic        action,
  input  logic [7:0]  label,
  input  logic [9:0]  depth,
  input  logic [9:0]  time_step,
  input  logic [1:0]  lane_select,
  input  logic [NSL*16-1:0] sc,
  input  logic [NFL*16-1:0] sf,
  output logic        cmd_valid,
  output cmd_t        cmd
);
  logic [8:0] group_limit;
  logic [9:0] surface_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_limit <= 9'd256;
      surface_depth <= 10'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_LIMIT) group_limit <= cfg_data[8:0];
      else surface_depth <= cfg_data;
    end
  end

  // drop label zero, and accumulating voxels at or above the limit
  always_comb begin
    cmd.rd = (action == ACT_READ);
    cmd.surf = (depth == surface_depth);
    cmd.grp = GW'(label - 8'd1);
    cmd.lane = lane_select;
    cmd.depth = depth;
    cmd.tstep = time_step;
    cmd.sc = sc;
    cmd.sf = sf;
    cmd_valid = take && (label != 8'd0) &&
                ((action == ACT_READ) || ({1'b0, label} < group_limit));
  end
endmodule

@@ rtl/core/lrs_queue.sv @@
// Two-entry command queue between front and back parts.
// Depends on lrs_pkg.
module lrs_queue import lrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output logic nonempty,
  output logic full,
  output cmd_t dout
);
  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign nonempty = (cnt != 2'd0);
  assign full = (cnt == 2'd2);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ rtl/core/lrs_back.sv @@
// Back part: clearing pass, read-modify-write of the group stores, read-out.
// Depends on lrs_pkg. Stores are read through a registered port and swept clear after reset.
module lrs_back import lrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        have,
  input  cmd_t        cmd,
  output logic        pop,
  output logic        clearing,
  output logic        done,
  output logic [31:0] voxel_count,
  output logic [31:0] surface_count,
  output logic [9:0]  deepest,
  output logic [9:0]  first_time,
  output logic [10:0] life_span,
  output logic [47:0] lane_sum,
  output logic [15:0] lane_min,
  output logic [15:0] lane_max,
  output logic [47:0] lane_surface_sum,
  output logic [15:0] surf_extreme,
  output logic [15:0] surf_min,
  output logic [15:0] surf_max
);
  typedef enum logic [1:0] {CLEAR, IDLE, FETCH, WORK} state_t;
  state_t state;
  logic [GW-1:0] sweep;

  logic [31:0] cnt_s [GROUPS];
  logic [31:0] scnt_s [GROUPS];
  logic [9:0]  dep_s [GROUPS];
  logic [9:0]  st_s [GROUPS];
  logic [10:0] life_s [GROUPS];
  logic [NSL*48-1:0] sum_s [GROUPS];
  logic [NSL*48-1:0] ssum_s [GROUPS];
  logic [NSL*32-1:0] mm_s [GROUPS];
  logic [NFL*48-1:0] sst_s [GROUPS];

  // registered read data of the group being worked on
  logic [31:0] cnt_r, scnt_r;
  logic [9:0]  dep_r, st_r;
  logic [10:0] life_r;
  logic [NSL*48-1:0] sum_r, ssum_r;
  logic [NSL*32-1:0] mm_r;
  logic [NFL*48-1:0] sst_r;

  cmd_t c;
  logic [9:0] st_new;
  logic [NSL*48-1:0] sum_n, ssum_n;
  logic [NSL*32-1:0] mm_n;
  logic [NFL*48-1:0] sst_n;

  assign clearing = (state == CLEAR);
  assign pop = (state == IDLE) && have;

  // compute the new group words from the fetched entries
  always_comb begin
    st_new = (c.tstep < st_r) ? c.tstep : st_r;
    for (int l = 0; l < NSL; l++) begin
      sum_n[l*48 +: 48] = sat_add(sum_r[l*48 +: 48], c.sc[l*16 +: 16]);
      ssum_n[l*48 +: 48] = sat_add(ssum_r[l*48 +: 48], c.sc[l*16 +: 16]);
      mm_n[l*32 +: 16] = upd_min(mm_r[l*32 +: 16], c.sc[l*16 +: 16]);
      mm_n[l*32+16 +: 16] = upd_max(mm_r[l*32+16 +: 16], c.sc[l*16 +: 16]);
    end
    for (int l = 0; l < NFL; l++) begin
      sst_n[l*48 +: 16] = upd_ext(sst_r[l*48 +: 16], c.sf[l*16 +: 16]);
      sst_n[l*48+16 +: 16] = upd_min(sst_r[l*48+16 +: 16], c.sf[l*16 +: 16]);
      sst_n[l*48+32 +: 16] = upd_max(sst_r[l*48+32 +: 16], c.sf[l*16 +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      sweep <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        CLEAR: begin
          cnt_s[sweep] <= '0; scnt_s[sweep] <= '0; dep_s[sweep] <= '0;
          st_s[sweep] <= '1; life_s[sweep] <= '0; sum_s[sweep] <= '0;
          ssum_s[sweep] <= '0; mm_s[sweep] <= '0; sst_s[sweep] <= '0;
          sweep <= sweep + 1'b1;
          if (sweep == GW'(GROUPS - 1)) state <= IDLE;
        end
        IDLE: begin
          if (have) begin
            c <= cmd;
            state <= FETCH;
          end
        end
        FETCH: begin
          cnt_r <= cnt_s[c.grp];
          scnt_r <= scnt_s[c.grp];
          dep_r <= dep_s[c.grp];
          st_r <= st_s[c.grp];
          life_r <= life_s[c.grp];
          sum_r <= sum_s[c.grp];
          ssum_r <= ssum_s[c.grp];
          mm_r <= mm_s[c.grp];
          sst_r <= sst_s[c.grp];
          state <= WORK;
        end
        WORK: begin
          state <= IDLE;
          if (c.rd) begin
            done <= 1'b1;
            voxel_count <= cnt_r;
            surface_count <= scnt_r;
            deepest <= dep_r;
            first_time <= st_r;
            life_span <= life_r;
            lane_sum <= sum_r[c.lane*48 +: 48];
            lane_min <= mm_r[c.lane*32 +: 16];
            lane_max <= mm_r[c.lane*32+16 +: 16];
            lane_surface_sum <= ssum_r[c.lane*48 +: 48];
            if (c.lane < 2'(NFL)) begin
              surf_extreme <= sst_r[c.lane*48 +: 16];
              surf_min <= sst_r[c.lane*48+16 +: 16];
              surf_max <= sst_r[c.lane*48+32 +: 16];
            end else begin
              surf_extreme <= '0; surf_min <= '0; surf_max <= '0;
            end
          end else begin
            st_s[c.grp] <= st_new;
            life_s[c.grp] <= {1'b0, c.tstep} - {1'b0, st_new};
            if (cnt_r != '1) cnt_s[c.grp] <= cnt_r + 32'd1;
            if (c.depth > dep_r) dep_s[c.grp] <= c.depth;
            sum_s[c.grp] <= sum_n;
            mm_s[c.grp] <= mm_n;
            if (c.surf) begin
              if (scnt_r != '1) scnt_s[c.grp] <= scnt_r + 32'd1;
              ssum_s[c.grp] <= ssum_n;
              sst_s[c.grp] <= sst_n;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/label_region_statistics.sv @@
// Top level of the label region statistics block.
// Depends on lrs_pkg, lrs_front, lrs_queue and lrs_back.
//
// Accumulates per-label voxel statistics and answers reads of one group and
// lane. After reset a clearing pass over all 256 groups runs with busy high;
// register writes are still taken. Then the back part takes each beat in turn
// (latch, registered fetch of the group's stores, then write-back or read-out)
// and takes no new beat until it is through with the last; busy rises when the
// two-entry queue is full. A read's result appears on the ports with done high
// for one cycle, after the beat passes the queue, the latch and the fetch
// registers; the receiver cannot stall it.
module label_region_statistics import lrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [7:0]  label,
  input  logic [9:0]  depth,
  input  logic [9:0]  time_step,
  input  logic [1:0]  lane_select,
  input  logic [15:0] scalar_a,
  input  logic [15:0] scalar_b,
  input  logic [15:0] scalar_c,
  input  logic [15:0] scalar_d,
  input  logic [15:0] surf_a,
  input  logic [15:0] surf_b,
  input  logic [15:0] surf_c,
  output logic        done,
  output logic [31:0] voxel_count,
  output logic [31:0] surface_count,
  output logic [9:0]  deepest,
  output logic [9:0]  first_time,
  output logic [10:0] life_span,
  output logic [47:0] lane_sum,
  output logic [15:0] lane_min,
  output logic [15:0] lane_max,
  output logic [47:0] lane_surface_sum,
  output logic [15:0] surf_extreme,
  output logic [15:0] surf_min,
  output logic [15:0] surf_max
);
  logic cmd_valid, full, have, pop, clearing;
  cmd_t cmd, qcmd;

  // hold off beats during clearing and while the queue is full
  assign busy = full || clearing;

  lrs_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .take(start && !busy), .action, .label, .depth, .time_step, .lane_select,
    .sc({scalar_d, scalar_c, scalar_b, scalar_a}),
    .sf({surf_c, surf_b, surf_a}),
    .cmd_valid, .cmd
  );

  lrs_queue u_queue (
    .clk, .rst, .push(cmd_valid), .din(cmd), .pop,
    .nonempty(have), .full, .dout(qcmd)
  );

  lrs_back u_back (
    .clk, .rst, .have, .cmd(qcmd), .pop, .clearing, .done,
    .voxel_count, .surface_count, .deepest, .first_time, .life_span,
    .lane_sum, .lane_min, .lane_max, .lane_surface_sum,
    .surf_extreme, .surf_min, .surf_max
  );
endmodule
